// ===== hdl/tfa_pkg.sv =====
// ----------------------------------------------------------------------------
// tfa_pkg
// Shared types, register codes and color tables for the texel format to
// ARGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package tfa_pkg;

  localparam int unsigned PaletteEntriesDef = 256;
  localparam int unsigned PaletteWordW      = 16;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 3;

  localparam logic [CfgIdxW-1:0] CfgPixelFormat = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTexelSize   = 1'd1;

  localparam logic [2:0] FmtRgba = 3'd0;
  localparam logic [2:0] FmtCi   = 3'd2;
  localparam logic [2:0] FmtIa   = 3'd3;
  localparam logic [2:0] FmtI    = 3'd4;

  localparam logic [1:0] Size4  = 2'd0;
  localparam logic [1:0] Size8  = 2'd1;
  localparam logic [1:0] Size16 = 2'd2;
  localparam logic [1:0] Size32 = 2'd3;

  localparam logic [2:0] FmtReset  = FmtRgba;
  localparam logic [1:0] SizeReset = Size16;

  localparam logic KindTexel   = 1'b0;
  localparam logic KindPalette = 1'b1;

  // floor(x * 255 / 31)
  localparam logic [7:0] Scale5To8 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // floor(x * 255 / 7)
  localparam logic [7:0] Scale3To8 [8] = '{
    8'd0, 8'd36, 8'd72, 8'd109, 8'd145, 8'd182, 8'd218, 8'd255
  };

  typedef struct packed {
    logic        kind;
    logic [31:0] data;
    logic [7:0]  palette_index;
    logic        lone_nibble;
    logic        final_req;
  } tex_in_t;

  typedef struct packed {
    logic [31:0] argb;
    logic        last_texel;
    logic        format_error;
  } tex_out_t;

  function automatic logic [31:0] word5551_to_argb(input logic [15:0] w);
    return {(w[0] ? 8'hff : 8'h00), Scale5To8[w[15:11]], Scale5To8[w[10:6]],
            Scale5To8[w[5:1]]};
  endfunction

  function automatic logic [31:0] gray(input logic [7:0] i, input logic [7:0] a);
    return {a, i, i, i};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tfa_ram.sv =====
// ----------------------------------------------------------------------------
// tfa_ram
// Generic synchronous RAM: one write port, two read ports with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ===== hdl/texel_format_to_argb.sv =====
// ----------------------------------------------------------------------------
// texel_format_to_argb
// Packed texel stream to 32-bit ARGB converter with a color-index palette.
// ----------------------------------------------------------------------------
// Accepts one item per cycle unless in_stall_o is high. A palette-write item
// updates the palette RAM and gives no result; a texel item gives one result,
// or two for a 4-bit word in a supported format without the lone-nibble flag,
// and such a word holds the output until both results are taken. Results
// pass the registered palette read (two read ports, so both nibbles of a CI4
// word look up together) and then the output register. The palette holds no
// defined value after reset; an entry must be written before a texel reads
// it. Configuration takes effect on the next item; the user must see that it is
// written only while the block is empty, as the block does not enforce it.
`default_nettype none

module texel_format_to_argb #(
  parameter int unsigned PALETTE_ENTRIES = tfa_pkg::PaletteEntriesDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tfa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [tfa_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire tfa_pkg::tex_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output tfa_pkg::tex_out_t                   out_data_o
);

  import tfa_pkg::*;

  localparam int unsigned PalAw      = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0]  PalEntries = 9'(PALETTE_ENTRIES);

  logic [2:0]  fmt_q;
  logic [1:0]  size_q;

  logic        s1_valid_q;
  logic [31:0] s1_data_q;
  logic        s1_lone_q;
  logic        s1_fin_q;
  logic        s1_rng_a_q;

  logic        out_valid_q;
  tex_out_t    out_q;
  logic        second_valid_q;
  tex_out_t    second_q;

  logic        in_xfer;
  logic        out_xfer;
  logic        s1_adv;
  logic        pal_we;
  logic        pal_re;
  logic [7:0]  idx_a;
  logic [7:0]  idx_b;
  logic        rng_a;
  logic [15:0] rdata_a;
  logic [15:0] rdata_b;
  logic [15:0] pw_a;
  tex_out_t    res0;
  tex_out_t    res1;
  logic        two;
  logic [32:0] wide;

  function automatic logic [31:0] conv_nib(input logic [2:0] fmt, input logic [3:0] v,
                                           input logic [15:0] pw);
    logic [31:0] r;
    r = '0;
    case (fmt)
      FmtIa:   r = gray(Scale3To8[v[3:1]], (v[0] ? 8'hff : 8'h00));
      FmtI:    r = gray({v, v}, {v, v});
      FmtCi:   r = word5551_to_argb(pw);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [32:0] conv_wide(input logic [2:0] fmt, input logic [1:0] size,
                                            input logic [31:0] d, input logic [15:0] pw);
    logic [32:0] r;
    r = '0;
    case (size)
      Size8: begin
        if (fmt == FmtIa) begin
          r = {1'b1, gray({d[7:4], d[7:4]}, {d[3:0], d[3:0]})};
        end else if (fmt == FmtI) begin
          r = {1'b1, gray(d[7:0], d[7:0])};
        end else if (fmt == FmtCi) begin
          r = {1'b1, word5551_to_argb(pw)};
        end
      end
      Size16: begin
        if (fmt == FmtRgba) begin
          r = {1'b1, word5551_to_argb(d[15:0])};
        end else if (fmt == FmtIa) begin
          r = {1'b1, gray(d[15:8], d[7:0])};
        end
      end
      Size32: begin
        if (fmt == FmtRgba) begin
          r = {1'b1, d[7:0], d[31:8]};
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  assign out_xfer   = out_valid_q & ~out_stall_i;
  assign s1_adv     = s1_valid_q & (~out_valid_q | (out_xfer & ~second_valid_q));
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  assign idx_a  = (size_q == Size4) ? {4'b0, in_data_i.data[7:4]} : in_data_i.data[7:0];
  assign idx_b  = {4'b0, in_data_i.data[3:0]};
  assign rng_a  = {1'b0, idx_a} < PalEntries;
  assign pal_re = in_xfer & (in_data_i.kind == KindTexel);
  assign pal_we = in_xfer & (in_data_i.kind == KindPalette) &
                  ({1'b0, in_data_i.palette_index} < PalEntries);

  tfa_ram #(
    .WIDTH (PaletteWordW),
    .DEPTH (PALETTE_ENTRIES),
    .AW    (PalAw)
  ) u_palette (
    .clk_i     (clk_i),
    .we_i      (pal_we),
    .waddr_i   (in_data_i.palette_index[PalAw-1:0]),
    .wdata_i   (in_data_i.data[15:0]),
    .re_i      (pal_re),
    .raddr_a_i (idx_a[PalAw-1:0]),
    .raddr_b_i (idx_b[PalAw-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign pw_a = s1_rng_a_q ? rdata_a : 16'h0000;
  assign wide = conv_wide(fmt_q, size_q, s1_data_q, pw_a);

  always_comb begin
    res0 = '0;
    res1 = '0;
    two  = 1'b0;
    if (size_q == Size4) begin
      if (!((fmt_q == FmtIa) || (fmt_q == FmtI) || (fmt_q == FmtCi))) begin
        res0.last_texel   = s1_fin_q;
        res0.format_error = 1'b1;
      end else if (s1_lone_q) begin
        res0.argb       = conv_nib(fmt_q, s1_data_q[7:4], pw_a);
        res0.last_texel = s1_fin_q;
      end else begin
        res0.argb       = conv_nib(fmt_q, s1_data_q[7:4], pw_a);
        res1.argb       = conv_nib(fmt_q, s1_data_q[3:0], rdata_b);
        res1.last_texel = s1_fin_q;
        two             = 1'b1;
      end
    end else begin
      res0.argb         = wide[31:0];
      res0.last_texel   = s1_fin_q;
      res0.format_error = ~wide[32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q          <= FmtReset;
      size_q         <= SizeReset;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      second_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgPixelFormat) begin
          fmt_q <= cfg_data_i;
        end else if (cfg_index_i == CfgTexelSize) begin
          size_q <= cfg_data_i[1:0];
        end
      end
      if (in_xfer) begin
        s1_valid_q <= (in_data_i.kind == KindTexel);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q    <= 1'b1;
        second_valid_q <= two;
      end else if (out_xfer) begin
        if (second_valid_q) begin
          second_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pal_re) begin
      s1_data_q  <= in_data_i.data;
      s1_lone_q  <= in_data_i.lone_nibble;
      s1_fin_q   <= in_data_i.final_req;
      s1_rng_a_q <= rng_a;
    end
    if (s1_adv) begin
      out_q    <= res0;
      second_q <= res1;
    end else if (out_xfer && second_valid_q) begin
      out_q <= second_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_valid_q |-> out_valid_q)
    else $error("second result pending without a first");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled while a stage is free");

  a_pair_keeps_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_valid_q |=> out_valid_q)
    else $error("output dropped while second result pending");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.format_error) |-> !second_valid_q)
    else $error("format error item produced two results");

endmodule

`default_nettype wire

// ===== tb/sv/texel_format_to_argb_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// texel_format_to_argb_test
// Self-checking bench for the texel format to ARGB converter. Directed texels
// cover field extremes, every format and size pair, palette loads and
// unsupported pairs. Random streams then run through all register settings.
// An in-bench predictor holds its own palette and register copies and queues
// the expected ARGB results, which are checked in order as they leave the
// block. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module texel_format_to_argb_test;

  import tfa_pkg::*;

  localparam int unsigned PalEntries  = PaletteEntriesDef;
  localparam int unsigned RandomItems = 1900;
  localparam int unsigned CycleLimit  = 400000;

  typedef enum {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgPixelFormat;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  tex_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  tex_out_t            out_data_o;

  logic [15:0] pal_words  [PalEntries];
  bit          pal_loaded [PalEntries];
  logic [2:0]  cur_fmt  = FmtReset;
  logic [1:0]  cur_size = SizeReset;
  tex_out_t    argb_due [$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_max = 2;

  stall_mode_e stall_mode = StallNone;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  texel_format_to_argb #(
    .PALETTE_ENTRIES(PalEntries)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("texel_format_to_argb_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= ((stall_tick % 3) != 0);
    endcase
  end

  // ---- predictor ----

  function automatic logic [7:0] scale5(logic [4:0] c);
    return 8'((int'(c) * 255) / 31);
  endfunction

  function automatic logic [31:0] expand_rgba5551(logic [15:0] w);
    return {{8{w[0]}}, scale5(w[15:11]), scale5(w[10:6]), scale5(w[5:1])};
  endfunction

  function automatic logic [15:0] pal_lookup(int unsigned idx);
    return (idx < PalEntries) ? pal_words[idx] : 16'h0000;
  endfunction

  function automatic bit nibble_argb(input logic [3:0] v, output logic [31:0] argb);
    logic [7:0] lvl;
    argb = 32'h0;
    if (cur_fmt == FmtIa) begin
      lvl  = 8'((int'(v[3:1]) * 255) / 7);
      argb = {{8{v[0]}}, lvl, lvl, lvl};
    end else if (cur_fmt == FmtI) begin
      lvl  = 8'(int'(v) * 17);
      argb = {lvl, lvl, lvl, lvl};
    end else if (cur_fmt == FmtCi) begin
      argb = expand_rgba5551(pal_lookup(32'(v)));
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit wide_argb(input logic [31:0] d, output logic [31:0] argb);
    logic [7:0] lo;
    logic [7:0] hi4;
    logic [7:0] lo4;
    lo   = d[7:0];
    hi4  = 8'(int'(lo[7:4]) * 17);
    lo4  = 8'(int'(lo[3:0]) * 17);
    argb = 32'h0;
    case (cur_size)
      Size8: begin
        if (cur_fmt == FmtIa) argb = {lo4, hi4, hi4, hi4};
        else if (cur_fmt == FmtI) argb = {lo, lo, lo, lo};
        else if (cur_fmt == FmtCi) argb = expand_rgba5551(pal_lookup(32'(lo)));
        else return 1'b0;
      end
      Size16: begin
        if (cur_fmt == FmtRgba) argb = expand_rgba5551(d[15:0]);
        else if (cur_fmt == FmtIa) argb = {lo, d[15:8], d[15:8], d[15:8]};
        else return 1'b0;
      end
      Size32: begin
        if (cur_fmt == FmtRgba) argb = {lo, d[31:8]};
        else return 1'b0;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void predict_item(tex_in_t it);
    logic [31:0] a0;
    logic [31:0] a1;
    bit          ok;
    if (it.kind == KindPalette) begin
      if (int'(it.palette_index) < PalEntries) begin
        pal_words[it.palette_index]  = it.data[15:0];
        pal_loaded[it.palette_index] = 1'b1;
      end
      return;
    end
    if (cur_size == Size4) begin
      ok = nibble_argb(it.data[7:4], a0);
      if (ok && !it.lone_nibble) ok = nibble_argb(it.data[3:0], a1);
      if (!ok) begin
        argb_due.push_back(tex_out_t'({32'h0, it.final_req, 1'b1}));
      end else if (it.lone_nibble) begin
        argb_due.push_back(tex_out_t'({a0, it.final_req, 1'b0}));
      end else begin
        argb_due.push_back(tex_out_t'({a0, 1'b0, 1'b0}));
        argb_due.push_back(tex_out_t'({a1, it.final_req, 1'b0}));
      end
    end else if (wide_argb(it.data, a0)) begin
      argb_due.push_back(tex_out_t'({a0, it.final_req, 1'b0}));
    end else begin
      argb_due.push_back(tex_out_t'({32'h0, it.final_req, 1'b1}));
    end
  endfunction

  // ---- result check ----

  function automatic void compare_texel(tex_out_t got);
    tex_out_t want;
    if (argb_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: argb %h last %b err %b",
                 got.argb, got.last_texel, got.format_error);
      return;
    end
    want = argb_due.pop_front();
    if (got.argb !== want.argb || got.last_texel !== want.last_texel ||
        got.format_error !== want.format_error) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected argb %h last %b err %b, got argb %h last %b err %b",
                 want.argb, want.last_texel, want.format_error,
                 got.argb, got.last_texel, got.format_error);
    end
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) compare_texel(out_data_o);
  end

  // ---- drivers ----

  task automatic push_item(tex_in_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    predict_item(it);
  endtask

  // Load any palette entry not yet loaded that a color-index texel would read before sending it.
  task automatic issue_item(tex_in_t it);
    tex_in_t    fill;
    logic [7:0] need [2];
    int         n;
    n = 0;
    if (it.kind == KindTexel && cur_fmt == FmtCi) begin
      if (cur_size == Size8) begin
        need[0] = it.data[7:0];
        n = 1;
      end else if (cur_size == Size4) begin
        need[0] = {4'h0, it.data[7:4]};
        need[1] = {4'h0, it.data[3:0]};
        n = 2;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (!pal_loaded[need[i]]) begin
        fill = tex_in_t'({KindPalette, 32'($urandom), need[i],
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))});
        push_item(fill);
      end
    end
    push_item(it);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (argb_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic configure(logic [2:0] fmt, logic [1:0] size);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgPixelFormat;
    cfg_data_i  <= fmt;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cur_fmt = fmt;
    cfg_index_i <= CfgTexelSize;
    cfg_data_i  <= {1'($urandom_range(0, 1)), size};
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cur_size = size;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic tex_in_t texel_item(logic [31:0] d, logic lone, logic fin);
    return tex_in_t'({KindTexel, d, 8'($urandom), lone, fin});
  endfunction

  function automatic tex_in_t palette_item(logic [7:0] idx, logic [31:0] w,
                                           logic lone, logic fin);
    return tex_in_t'({KindPalette, w, idx, lone, fin});
  endfunction

  function automatic bit pair_ok(logic [2:0] fmt, logic [1:0] size);
    case (size)
      Size4, Size8: return fmt == FmtIa || fmt == FmtI || fmt == FmtCi;
      Size16:       return fmt == FmtRgba || fmt == FmtIa;
      default:      return fmt == FmtRgba;
    endcase
  endfunction

  // ---- tests ----

  task automatic test_reset_format();
    push_item(texel_item(32'h0000_0000, 1'b0, 1'b0));
    push_item(texel_item(32'hffff_fffe, 1'b0, 1'b0));
    push_item(texel_item(32'h0000_0001, 1'b0, 1'b0));
    push_item(texel_item(32'ha5a5_f83f, 1'b1, 1'b1));
  endtask

  task automatic test_palette_lookup();
    configure(FmtCi, Size8);
    push_item(palette_item(8'h00, 32'hffff_0000, 1'b1, 1'b1));
    push_item(palette_item(8'hff, 32'h0000_ffff, 1'b0, 1'b0));
    push_item(palette_item(8'h0f, 32'h5a5a_07c1, 1'b0, 1'b0));
    push_item(texel_item(32'hffff_ff00, 1'b1, 1'b0));
    push_item(texel_item(32'h0000_00ff, 1'b0, 1'b1));
    // rewrite an entry and then read it again
    push_item(palette_item(8'h00, 32'h0000_f801, 1'b0, 1'b0));
    push_item(texel_item(32'h0000_0000, 1'b0, 1'b0));
    configure(FmtCi, Size4);
    push_item(texel_item(32'hffff_ff0f, 1'b0, 1'b1));
    push_item(texel_item(32'h0000_00f0, 1'b1, 1'b1));
  endtask

  task automatic test_narrow_and_wide();
    configure(FmtIa, Size4);
    push_item(texel_item(32'h0000_00f0, 1'b0, 1'b0));
    push_item(texel_item(32'hffff_ff1e, 1'b1, 1'b1));
    configure(FmtI, Size4);
    push_item(texel_item(32'h0000_00f0, 1'b0, 1'b1));
    configure(FmtIa, Size8);
    push_item(texel_item(32'hffff_fff0, 1'b1, 1'b0));
    configure(FmtI, Size8);
    push_item(texel_item(32'h0000_00ff, 1'b0, 1'b1));
    configure(FmtIa, Size16);
    push_item(texel_item(32'hffff_00ff, 1'b0, 1'b0));
    configure(FmtRgba, Size32);
    push_item(texel_item(32'h1122_3344, 1'b1, 1'b1));
  endtask

  task automatic test_unsupported_pairs();
    configure(FmtRgba, Size4);
    push_item(texel_item(32'hffff_ffff, 1'b0, 1'b1));
    configure(FmtI, Size16);
    push_item(texel_item(32'h0000_0000, 1'b1, 1'b0));
  endtask

  task automatic test_random_streams();
    int unsigned phase;
    int unsigned count;
    int unsigned sent;
    int unsigned pick;
    logic [2:0]  fmt;
    logic [1:0]  size;
    tex_in_t     it;
    phase = 0;
    sent  = 0;
    while (sent < RandomItems) begin
      if (phase < 32) begin
        fmt  = phase[2:0];
        size = phase[4:3];
      end else begin
        fmt  = 3'($urandom_range(0, 7));
        size = 2'($urandom_range(0, 3));
        while (!pair_ok(fmt, size) && $urandom_range(0, 3) != 0) begin
          fmt  = 3'($urandom_range(0, 7));
          size = 2'($urandom_range(0, 3));
        end
      end
      configure(fmt, size);
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      count   = $urandom_range(12, 48);
      repeat (count) begin
        pick = $urandom_range(0, 7);
        it.kind = ($urandom_range(0, 9) == 0) ? KindPalette : KindTexel;
        if (pick == 0) it.data = 32'h0000_0000;
        else if (pick == 1) it.data = 32'hffff_ffff;
        else it.data = $urandom;
        it.palette_index = 8'($urandom_range(0, 255));
        it.lone_nibble   = ($urandom_range(0, 3) == 0);
        it.final_req     = ($urandom_range(0, 7) == 0);
        issue_item(it);
        sent++;
      end
      phase++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_format();
    test_palette_lookup();
    test_narrow_and_wide();
    test_unsupported_pairs();
    test_random_streams();

    in_valid_i <= 1'b0;
    while (argb_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && argb_due.size() == 0) begin
      $display("texel_format_to_argb_test OK");
    end else begin
      $display("texel_format_to_argb_test NOT OK");
    end
    $finish;
  end

endmodule
